/* rtl/four_level_page_table_walker_defines.svh */
// Assertion macros for the four-level page table walker.
// Expects signals clk and arst_n in the scope of each use.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ptw_pkg.sv */
// Shared types, codes and helpers of the page table walker.
// No dependencies.
package ptw_pkg;

	localparam int ADDR_W      = 52;
	localparam int VIRT_W      = 48;
	localparam int DATA_W      = 64;
	localparam int INDEX_BITS  = 9;
	localparam int OFFSET_BITS = 12;

	// Input modes
	localparam logic [2:0] MODE_TRANSLATE  = 3'd0;
	localparam logic [2:0] MODE_MAP        = 3'd1;
	localparam logic [2:0] MODE_UNMAP      = 3'd2;
	localparam logic [2:0] MODE_READ_RESP  = 3'd3;
	localparam logic [2:0] MODE_ALLOC_RESP = 3'd4;

	// Result kinds
	localparam logic [2:0] KIND_READ    = 3'd0;
	localparam logic [2:0] KIND_WRITE   = 3'd1;
	localparam logic [2:0] KIND_ZERO    = 3'd2;
	localparam logic [2:0] KIND_ALLOC   = 3'd3;
	localparam logic [2:0] KIND_DONE    = 3'd4;
	localparam logic [2:0] KIND_REFUSED = 3'd5;

	// Operations held during a walk
	localparam logic [1:0] OP_TRANSLATE = 2'd0;
	localparam logic [1:0] OP_MAP       = 2'd1;
	localparam logic [1:0] OP_UNMAP     = 2'd2;

	// Entry flag bits
	localparam logic [DATA_W-1:0] PTE_P = 64'h1;
	localparam logic [DATA_W-1:0] PTE_W = 64'h2;
	localparam logic [DATA_W-1:0] PTE_U = 64'h4;

	typedef struct packed {
		logic [2:0]        mode;
		logic [ADDR_W-1:0] root_table_addr;
		logic [VIRT_W-1:0] vaddr;
		logic [ADDR_W-1:0] target_phys_addr;
		logic [DATA_W-1:0] map_flags;
		logic [DATA_W-1:0] read_data;
		logic [ADDR_W-1:0] alloc_page_addr;
	} req_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ADDR_W-1:0] mem_addr;
		logic [DATA_W-1:0] write_data;
		logic [ADDR_W-1:0] result_addr;
		logic              fault;
		logic              invalidate;
		logic              last;
	} res_t;

	// Results caused by one input beat, in order
	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
		res_t       third;
	} step_t;

	function automatic res_t make_res(
		logic [2:0]        kind,
		logic [ADDR_W-1:0] mem_addr,
		logic [DATA_W-1:0] write_data,
		logic [ADDR_W-1:0] result_addr,
		logic              fault,
		logic              invalidate,
		logic              last
	);
		res_t r;
		r.kind        = kind;
		r.mem_addr    = mem_addr;
		r.write_data  = write_data;
		r.result_addr = result_addr;
		r.fault       = fault;
		r.invalidate  = invalidate;
		r.last        = last;
		return r;
	endfunction

endpackage

/* rtl/ptw_walk_ctrl.sv */
// Walk state and per-beat decision logic of the page table walker.
// Depends on ptw_pkg.
module ptw_walk_ctrl #(
	parameter int LEVELS         = 4,
	parameter int PHYS_ADDR_BITS = 52
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	input  ptw_pkg::req_t  item,
	output ptw_pkg::step_t step
);
	import ptw_pkg::*;

	localparam int LVL_W = $clog2(LEVELS);
	localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);
	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - PHYS_ADDR_BITS);
	localparam logic [ADDR_W-1:0] PAGE_MASK =
		ADDR_MASK & ~ADDR_W'((1 << OFFSET_BITS) - 1);

	// Walk state
	logic              walk_busy_q, walk_busy_d;
	logic [1:0]        op_q, op_d;
	logic [LVL_W-1:0]  level_q, level_d;
	logic              await_alloc_q, await_alloc_d;
	logic [VIRT_W-1:0] virt_q, virt_d;
	logic [ADDR_W-1:0] target_q, target_d;
	logic [DATA_W-1:0] flags_q, flags_d;
	logic [ADDR_W-1:0] pea_q, pea_d;

	logic              present;
	logic [ADDR_W-1:0] page;
	logic [LVL_W-1:0]  level_inc;

	// Entry address: table base plus the level's index times eight
	function automatic logic [ADDR_W-1:0] entry_addr(
		logic [ADDR_W-1:0] base,
		logic [LVL_W-1:0]  lvl,
		logic [VIRT_W-1:0] virt
	);
		logic [INDEX_BITS-1:0] idx;
		idx = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (lvl == LVL_W'(i))
				idx = INDEX_BITS'(virt >> (OFFSET_BITS + INDEX_BITS * (LEVELS - 1 - i)));
		end
		return (base & PAGE_MASK) | ADDR_W'({idx, 3'b000});
	endfunction

	assign present   = item.read_data[0];
	assign page      = item.alloc_page_addr & PAGE_MASK;
	assign level_inc = level_q + LVL_W'(1);

	// Next state and results for the beat in the input register
	always_comb begin
		walk_busy_d   = walk_busy_q;
		op_d          = op_q;
		level_d       = level_q;
		await_alloc_d = await_alloc_q;
		virt_d        = virt_q;
		target_d      = target_q;
		flags_d       = flags_q;
		pea_d         = pea_q;
		step          = '0;

		case (item.mode)
			MODE_TRANSLATE, MODE_MAP, MODE_UNMAP: begin
				if (walk_busy_q) begin
					step.count = 2'd1;
					step.first = make_res(KIND_REFUSED, '0, '0, '0, 1'b0, 1'b0, 1'b1);
				end else begin
					walk_busy_d   = 1'b1;
					op_d          = item.mode[1:0];
					level_d       = '0;
					await_alloc_d = 1'b0;
					virt_d        = item.vaddr;
					target_d      = item.target_phys_addr;
					flags_d       = item.map_flags;
					pea_d         = entry_addr(item.root_table_addr, '0, item.vaddr);
					step.count    = 2'd1;
					step.first    = make_res(KIND_READ, pea_d, '0, '0, 1'b0, 1'b0, 1'b1);
				end
			end
			MODE_READ_RESP: begin
				if (walk_busy_q && !await_alloc_q) begin
					step.count = 2'd1;
					if (level_q != LAST_LVL) begin
						// Intermediate level
						if (present) begin
							level_d    = level_inc;
							pea_d      = entry_addr(item.read_data[ADDR_W-1:0], level_inc, virt_q);
							step.first = make_res(KIND_READ, pea_d, '0, '0, 1'b0, 1'b0, 1'b1);
						end else if (op_q == OP_MAP) begin
							await_alloc_d = 1'b1;
							step.first = make_res(KIND_ALLOC, '0, '0, '0, 1'b0, 1'b0, 1'b1);
						end else begin
							walk_busy_d = 1'b0;
							step.first  = make_res(KIND_DONE, '0, '0, '0,
								op_q == OP_TRANSLATE, 1'b0, 1'b1);
						end
					end else begin
						// Leaf level
						walk_busy_d = 1'b0;
						if (op_q == OP_TRANSLATE) begin
							if (present)
								step.first = make_res(KIND_DONE, '0, '0,
									(item.read_data[ADDR_W-1:0] & PAGE_MASK) |
									ADDR_W'(virt_q[OFFSET_BITS-1:0]),
									1'b0, 1'b0, 1'b1);
							else
								step.first = make_res(KIND_DONE, '0, '0, '0, 1'b1, 1'b0, 1'b1);
						end else if (op_q == OP_MAP) begin
							step.count  = 2'd2;
							step.first  = make_res(KIND_WRITE, pea_q,
								DATA_W'(target_q & PAGE_MASK) | flags_q | PTE_P,
								'0, 1'b0, 1'b0, 1'b0);
							step.second = make_res(KIND_DONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
						end else begin
							step.count  = 2'd2;
							step.first  = make_res(KIND_WRITE, pea_q, '0, '0, 1'b0, 1'b0, 1'b0);
							step.second = make_res(KIND_DONE, '0, '0, '0, 1'b0, 1'b1, 1'b1);
						end
					end
				end
			end
			MODE_ALLOC_RESP: begin
				if (walk_busy_q && await_alloc_q) begin
					// Zero the new table, link it, read the next entry from it
					await_alloc_d = 1'b0;
					level_d       = (level_q != LAST_LVL) ? level_inc : level_q;
					pea_d         = entry_addr(page, level_d, virt_q);
					step.count    = 2'd3;
					step.first    = make_res(KIND_ZERO, page, '0, '0, 1'b0, 1'b0, 1'b0);
					step.second   = make_res(KIND_WRITE, pea_q,
						DATA_W'(page) | PTE_P | PTE_W | PTE_U, '0, 1'b0, 1'b0, 1'b0);
					step.third    = make_res(KIND_READ, pea_d, '0, '0, 1'b0, 1'b0, 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_busy_q   <= 1'b0;
			op_q          <= OP_TRANSLATE;
			level_q       <= '0;
			await_alloc_q <= 1'b0;
		end else if (valid) begin
			walk_busy_q   <= walk_busy_d;
			op_q          <= op_d;
			level_q       <= level_d;
			await_alloc_q <= await_alloc_d;
		end
	end

	// Saved command payload and last entry address
	always_ff @(posedge clk) begin
		if (valid) begin
			virt_q   <= virt_d;
			target_q <= target_d;
			flags_q  <= flags_d;
			pea_q    <= pea_d;
		end
	end

endmodule

/* rtl/ptw_result_seq.sv */
// Result register and pending-result buffer: sends one result per cycle.
// Depends on ptw_pkg and four_level_page_table_walker_defines.svh.
`include "four_level_page_table_walker_defines.svh"

module ptw_result_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_valid,
	input  ptw_pkg::step_t step,
	output logic           strobe,
	output ptw_pkg::res_t  result,
	output logic           hold
);
	import ptw_pkg::*;

	logic [1:0] pend_cnt_q;
	res_t       pend_q [2];
	res_t       result_q;
	logic       strobe_q;
	logic       load_new;
	logic       load_pend;

	assign load_pend = (pend_cnt_q != 2'd0);
	assign load_new  = !load_pend && step_valid && (step.count != 2'd0);

	// Strobe and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q   <= 1'b0;
			pend_cnt_q <= 2'd0;
		end else if (load_pend) begin
			strobe_q   <= 1'b1;
			pend_cnt_q <= pend_cnt_q - 2'd1;
		end else if (load_new) begin
			strobe_q   <= 1'b1;
			pend_cnt_q <= step.count - 2'd1;
		end else begin
			strobe_q   <= 1'b0;
		end
	end

	// Payload: first result straight out, the rest queued
	always_ff @(posedge clk) begin
		if (load_pend) begin
			result_q  <= pend_q[0];
			pend_q[0] <= pend_q[1];
		end else if (load_new) begin
			result_q  <= step.first;
			pend_q[0] <= step.second;
			pend_q[1] <= step.third;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;
	// Two results still queued: the next beat cannot be taken yet
	assign hold   = pend_cnt_q[1];

	`PTW_ASSERT_NXT(a_burst_contiguous, strobe_q && !result_q.last, strobe_q, "result burst broken")
	`PTW_ASSERT_IMP(a_step_on_empty, step_valid, pend_cnt_q == 2'd0, "beat decided while queue busy")
	`PTW_ASSERT_NXT(a_triple_queued, step_valid && step.count == 2'd3,
		strobe_q && pend_cnt_q == 2'd2, "three-result beat not queued")
	`PTW_ASSERT_NXT(a_pend_drains, pend_cnt_q != 2'd0, strobe_q, "queued result not sent")
	`PTW_ASSERT_IMP(a_count_range, 1'b1, pend_cnt_q != 2'd3, "queue overfilled")

endmodule

/* rtl/four_level_page_table_walker.sv */
// Top level of the four-level page table walker: input register and busy.
// Depends on ptw_pkg, ptw_walk_ctrl and ptw_result_seq.
//
// A beat (command or memory response) is taken when start is high and busy
// is low, held in the input register and decided there; its first result
// appears on the result ports the cycle after that. Results are held for
// exactly one cycle with strobe high and cannot be stalled. A beat that
// causes one result frees the block at once, so such beats can follow every
// cycle. An allocate response causes three results and a leaf write on map
// or unmap causes two; they leave on consecutive cycles from a two-entry
// result buffer, and busy stays high until only one of them is left to
// send. Commands during a walk get a refused result; stray responses and
// unused modes are dropped without a result.
module four_level_page_table_walker #(
	parameter int LEVELS         = 4,
	parameter int PHYS_ADDR_BITS = 52
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ptw_pkg::req_t request,
	output logic          strobe,
	output ptw_pkg::res_t result
);
	import ptw_pkg::*;

	logic  valid_s1;
	req_t  req_s1;
	step_t step;
	logic  hold;
	logic  accept;

	assign accept = start && !busy;
	assign busy   = hold || (valid_s1 && step.count > 2'd1);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= request;
		end
	end

	ptw_walk_ctrl #(
		.LEVELS         (LEVELS),
		.PHYS_ADDR_BITS (PHYS_ADDR_BITS)
	) u_walk_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.item   (req_s1),
		.step   (step)
	);

	ptw_result_seq u_result_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_valid (valid_s1),
		.step       (step),
		.strobe     (strobe),
		.result     (result),
		.hold       (hold)
	);

endmodule
